// ===== rtl/flux_stream_byte_decoder_macros.svh =====
// Assertion macros shared by the decoder's checker
`ifndef FLUX_STREAM_BYTE_DECODER_MACROS_SVH
`define FLUX_STREAM_BYTE_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FSB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FSB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fsb_pkg.sv =====
// Shared types and constants of the flux stream byte decoder
package fsb_pkg;

    // Default tick accumulator width
    localparam int FSB_ACCUM_BITS = 32;

    // Conversion constants
    localparam int          PS_PER_NS         = 1000;
    localparam logic [19:0] TICK_PERIOD_RESET = 20'd41619;

    // Result kinds
    localparam logic [1:0] KIND_FLUX  = 2'd0;
    localparam logic [1:0] KIND_INDEX = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    // Stop causes
    localparam logic [31:0] CAUSE_INVALID = 32'd0;
    localparam logic [31:0] CAUSE_EOF     = 32'd1;
    localparam logic [31:0] CAUSE_UNKNOWN = 32'd2;

    // Event handed from the parser to the conversion pipeline
    typedef struct packed {
        logic        is_flux;
        logic [1:0]  kind;
        logic [31:0] value;
        logic [31:0] pos;
    } fsb_evt_t;

endpackage

// ===== rtl/fsb_queue.sv =====
// Two-entry register queue between the parser and the conversion pipeline
module fsb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);
    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full      = (count_reg == 2'(DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (rd_en)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/fsb_front.sv =====
// Stream parser: classifies each byte, tracks cells and blocks, emits events
module fsb_front #(
    parameter int ACCUM_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            stream_byte,
    input  logic                  track_start,
    output logic                  evt_valid,
    output fsb_pkg::fsb_evt_t     evt,
    output logic [ACCUM_BITS-1:0] evt_ticks
);
    import fsb_pkg::*;

    // Parse phases
    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_FLUX_LO     = 4'd1;
    localparam logic [3:0] PH_FLUX3_HI    = 4'd2;
    localparam logic [3:0] PH_SKIP2       = 4'd3;
    localparam logic [3:0] PH_SKIP1       = 4'd4;
    localparam logic [3:0] PH_OOB_SUB     = 4'd5;
    localparam logic [3:0] PH_OOB_LEN_LO  = 4'd6;
    localparam logic [3:0] PH_OOB_LEN_HI  = 4'd7;
    localparam logic [3:0] PH_OOB_PAYLOAD = 4'd8;

    // Header bytes
    localparam logic [7:0] B_FLUX2_MAX = 8'h07;
    localparam logic [7:0] B_NOP1      = 8'h08;
    localparam logic [7:0] B_NOP2      = 8'h09;
    localparam logic [7:0] B_NOP3      = 8'h0a;
    localparam logic [7:0] B_OVERFLOW  = 8'h0b;
    localparam logic [7:0] B_FLUX3     = 8'h0c;
    localparam logic [7:0] B_OOB       = 8'h0d;

    // Block subtypes
    localparam logic [7:0] SUB_INVALID = 8'h00;
    localparam logic [7:0] SUB_INDEX   = 8'h02;
    localparam logic [7:0] SUB_END     = 8'h03;
    localparam logic [7:0] SUB_MAX     = 8'h04;
    localparam logic [7:0] SUB_EOF     = 8'h0d;

    localparam logic [16:0] OVERFLOW_TICKS = 17'h10000;

    logic [3:0]            phase_reg, phase_next, c_phase;
    logic [ACCUM_BITS-1:0] acc_reg, acc_next, c_acc;
    logic [7:0]            hold_reg, hold_next, c_hold;
    logic [31:0]           pos_reg, pos_next, c_pos;
    logic [31:0]           cellpos_reg, cellpos_next, c_cellpos;
    logic [7:0]            subtype_reg, subtype_next, c_subtype;
    logic [15:0]           length_reg, length_next, c_length;
    logic [15:0]           pcount_reg, pcount_next, c_pcount;
    logic [31:0]           pword_reg, pword_next, c_pword;
    logic                  stopped_reg, stopped_next, c_stopped;

    logic [15:0] new_length;
    logic [15:0] pcount_inc;
    logic [15:0] word_base;
    logic [15:0] word_rel;
    logic        blk_done;
    logic        emit;
    fsb_evt_t    evt_c;
    logic [ACCUM_BITS-1:0] ticks_c;

    // Add with saturation at the accumulator maximum
    function automatic logic [ACCUM_BITS-1:0] sat_add(
        input logic [ACCUM_BITS-1:0] a,
        input logic [16:0]           b
    );
        logic [ACCUM_BITS:0] s;
        s = {1'b0, a} + (ACCUM_BITS+1)'(b);
        return s[ACCUM_BITS] ? '1 : s[ACCUM_BITS-1:0];
    endfunction

    // Track start clears the parser before this byte
    always_comb
    begin
        c_phase   = track_start ? PH_IDLE : phase_reg;
        c_acc     = track_start ? '0      : acc_reg;
        c_hold    = track_start ? 8'd0    : hold_reg;
        c_pos     = track_start ? 32'd0   : pos_reg;
        c_cellpos = track_start ? 32'd0   : cellpos_reg;
        c_subtype = track_start ? 8'd0    : subtype_reg;
        c_length  = track_start ? 16'd0   : length_reg;
        c_pcount  = track_start ? 16'd0   : pcount_reg;
        c_pword   = track_start ? 32'd0   : pword_reg;
        c_stopped = track_start ? 1'b0    : stopped_reg;
    end

    // Byte decode
    always_comb
    begin
        phase_next   = c_phase;
        acc_next     = c_acc;
        hold_next    = c_hold;
        pos_next     = c_pos;
        cellpos_next = c_cellpos;
        subtype_next = c_subtype;
        length_next  = c_length;
        pcount_next  = c_pcount;
        pword_next   = c_pword;
        stopped_next = c_stopped;
        emit         = 1'b0;
        blk_done     = 1'b0;
        evt_c        = '0;
        ticks_c      = '0;
        new_length   = {stream_byte, c_length[7:0]};
        pcount_inc   = c_pcount + 16'd1;
        word_base    = (c_subtype == SUB_END) ? 16'd4 : 16'd0;
        word_rel     = c_pcount - word_base;

        if (!c_stopped)
        begin
            unique case (c_phase)
                PH_FLUX_LO:
                begin
                    pos_next      = c_pos + 32'd1;
                    emit          = 1'b1;
                    evt_c.is_flux = 1'b1;
                    evt_c.kind    = KIND_FLUX;
                    evt_c.pos     = c_cellpos;
                    ticks_c       = sat_add(c_acc, {1'b0, c_hold, stream_byte});
                    acc_next      = '0;
                    phase_next    = PH_IDLE;
                end
                PH_FLUX3_HI:
                begin
                    pos_next   = c_pos + 32'd1;
                    hold_next  = stream_byte;
                    phase_next = PH_FLUX_LO;
                end
                PH_SKIP2:
                begin
                    pos_next   = c_pos + 32'd1;
                    phase_next = PH_SKIP1;
                end
                PH_SKIP1:
                begin
                    pos_next   = c_pos + 32'd1;
                    phase_next = PH_IDLE;
                end
                PH_OOB_SUB:
                begin
                    subtype_next = stream_byte;
                    phase_next   = PH_OOB_LEN_LO;
                end
                PH_OOB_LEN_LO:
                begin
                    length_next = {8'd0, stream_byte};
                    phase_next  = PH_OOB_LEN_HI;
                end
                PH_OOB_LEN_HI:
                begin
                    length_next = new_length;
                    pcount_next = 16'd0;
                    pword_next  = 32'd0;
                    if (c_subtype == SUB_INVALID || c_subtype == SUB_EOF ||
                        c_subtype > SUB_MAX)
                    begin
                        stopped_next = 1'b1;
                        phase_next   = PH_IDLE;
                        emit         = 1'b1;
                        evt_c.kind   = KIND_STOP;
                        if (c_subtype == SUB_INVALID)
                        begin
                            evt_c.value = CAUSE_INVALID;
                        end
                        else if (c_subtype == SUB_EOF)
                        begin
                            evt_c.value = CAUSE_EOF;
                        end
                        else
                        begin
                            evt_c.value = CAUSE_UNKNOWN;
                        end
                    end
                    else if (new_length == 16'd0)
                    begin
                        phase_next = PH_IDLE;
                        blk_done   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_OOB_PAYLOAD;
                    end
                end
                PH_OOB_PAYLOAD:
                begin
                    // Collect the reported dword, little endian
                    if (c_pcount >= word_base && word_rel < 16'd4)
                    begin
                        pword_next = c_pword |
                                     (32'(stream_byte) << {word_rel[1:0], 3'b000});
                    end
                    pcount_next = pcount_inc;
                    if (pcount_inc == c_length)
                    begin
                        phase_next = PH_IDLE;
                        blk_done   = 1'b1;
                    end
                end
                default:
                begin
                    // Cell header
                    phase_next = PH_IDLE;
                    if (stream_byte == B_OOB)
                    begin
                        phase_next = PH_OOB_SUB;
                    end
                    else
                    begin
                        cellpos_next = c_pos;
                        pos_next     = c_pos + 32'd1;
                        if (stream_byte <= B_FLUX2_MAX)
                        begin
                            hold_next  = stream_byte;
                            phase_next = PH_FLUX_LO;
                        end
                        else if (stream_byte == B_FLUX3)
                        begin
                            phase_next = PH_FLUX3_HI;
                        end
                        else if (stream_byte == B_NOP1)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (stream_byte == B_NOP2)
                        begin
                            phase_next = PH_SKIP1;
                        end
                        else if (stream_byte == B_NOP3)
                        begin
                            phase_next = PH_SKIP2;
                        end
                        else if (stream_byte == B_OVERFLOW)
                        begin
                            acc_next = sat_add(c_acc, OVERFLOW_TICKS);
                        end
                        else
                        begin
                            emit          = 1'b1;
                            evt_c.is_flux = 1'b1;
                            evt_c.kind    = KIND_FLUX;
                            evt_c.pos     = c_pos;
                            ticks_c       = sat_add(c_acc, {9'd0, stream_byte});
                            acc_next      = '0;
                        end
                    end
                end
            endcase
        end

        // End of an index or stream-end block
        if (blk_done)
        begin
            if (c_subtype == SUB_INDEX)
            begin
                emit        = 1'b1;
                evt_c.kind  = KIND_INDEX;
                evt_c.value = pword_next;
            end
            else if (c_subtype == SUB_END)
            begin
                emit        = 1'b1;
                evt_c.kind  = KIND_END;
                evt_c.value = pword_next;
            end
        end
    end

    assign evt_valid = accept && emit;
    assign evt       = evt_c;
    assign evt_ticks = ticks_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            acc_reg     <= '0;
            hold_reg    <= 8'd0;
            pos_reg     <= 32'd0;
            cellpos_reg <= 32'd0;
            subtype_reg <= 8'd0;
            length_reg  <= 16'd0;
            pcount_reg  <= 16'd0;
            pword_reg   <= 32'd0;
            stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            hold_reg    <= hold_next;
            pos_reg     <= pos_next;
            cellpos_reg <= cellpos_next;
            subtype_reg <= subtype_next;
            length_reg  <= length_next;
            pcount_reg  <= pcount_next;
            pword_reg   <= pword_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// ===== rtl/fsb_back.sv =====
// Conversion pipeline: ticks times period, divided by 1000, saturated to 32 bits
module fsb_back #(
    parameter int ACCUM_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [19:0]           tick_period_ps,
    input  logic                  in_valid,
    input  fsb_pkg::fsb_evt_t     in_evt,
    input  logic [ACCUM_BITS-1:0] in_ticks,
    output logic                  in_take,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            kind,
    output logic [31:0]           value,
    output logic [31:0]           cell_position
);
    import fsb_pkg::*;

    // Products below 1000 * 2^32 fit in 42 bits
    localparam int PROD_BITS = 42;
    localparam int HALF_BITS = PROD_BITS / 2;
    localparam int MUL_BITS  = HALF_BITS + 20;
    localparam int SUM_BITS  = MUL_BITS + HALF_BITS;
    localparam int EXT_BITS  = (ACCUM_BITS > PROD_BITS) ? ACCUM_BITS : PROD_BITS + 1;
    localparam int REM_BITS  = 10;
    localparam int DIV_STEP  = 4;
    localparam int NUM_DIV   = 32 / DIV_STEP;
    localparam logic [SUM_BITS-1:0] NS_LIMIT = SUM_BITS'(PS_PER_NS) << 32;

    typedef struct packed {
        logic                valid;
        fsb_evt_t            evt;
        logic [MUL_BITS-1:0] lo;
        logic [MUL_BITS-1:0] hi;
        logic                upper;
    } fsb_mul_t;

    typedef struct packed {
        logic                valid;
        logic                is_flux;
        logic [1:0]          kind;
        logic [31:0]         value;
        logic [31:0]         pos;
        logic [REM_BITS-1:0] rem;
        logic [31:0]         pbits;
        logic                sat;
    } fsb_div_t;

    fsb_mul_t mul_reg;
    fsb_div_t stg_reg [NUM_DIV+1];

    logic                advance;
    logic [EXT_BITS-1:0] ticks_ext;
    logic [SUM_BITS-1:0] prod;
    fsb_mul_t            mul_c;
    fsb_div_t            div0_c;

    // Several quotient bits per stage, restoring long division by 1000
    function automatic fsb_div_t div_step(input fsb_div_t d);
        fsb_div_t            o;
        logic [REM_BITS:0]   r2;
        o = d;
        if (d.is_flux)
        begin
            for (int k = 0; k < DIV_STEP; k++)
            begin
                r2      = {o.rem, o.pbits[31]};
                o.pbits = {o.pbits[30:0], 1'b0};
                if (r2 >= (REM_BITS+1)'(PS_PER_NS))
                begin
                    o.rem   = REM_BITS'(r2 - (REM_BITS+1)'(PS_PER_NS));
                    o.value = {o.value[30:0], 1'b1};
                end
                else
                begin
                    o.rem   = r2[REM_BITS-1:0];
                    o.value = {o.value[30:0], 1'b0};
                end
            end
        end
        return o;
    endfunction

    // Whole pipeline moves unless the output holds an unread result
    assign advance = !stg_reg[NUM_DIV].valid || pop;
    assign in_take = advance && in_valid;

    // Multiply stage: two 21 x 20 partial products
    always_comb
    begin
        ticks_ext   = EXT_BITS'(in_ticks);
        mul_c.valid = in_valid;
        mul_c.evt   = in_evt;
        mul_c.lo    = MUL_BITS'(ticks_ext[HALF_BITS-1:0]) * MUL_BITS'(tick_period_ps);
        mul_c.hi    = MUL_BITS'(ticks_ext[PROD_BITS-1:HALF_BITS]) *
                      MUL_BITS'(tick_period_ps);
        mul_c.upper = (|ticks_ext[EXT_BITS-1:PROD_BITS]) && (tick_period_ps != 20'd0);
    end

    // Sum stage: full product, saturation check, division setup
    always_comb
    begin
        prod           = SUM_BITS'(mul_reg.lo) + {mul_reg.hi, HALF_BITS'(0)};
        div0_c.valid   = mul_reg.valid;
        div0_c.is_flux = mul_reg.evt.is_flux;
        div0_c.kind    = mul_reg.evt.kind;
        div0_c.value   = mul_reg.evt.is_flux ? 32'd0 : mul_reg.evt.value;
        div0_c.pos     = mul_reg.evt.pos;
        div0_c.rem     = prod[PROD_BITS-1:32];
        div0_c.pbits   = prod[31:0];
        div0_c.sat     = mul_reg.evt.is_flux && (mul_reg.upper || prod >= NS_LIMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg <= '0;
            for (int i = 0; i <= NUM_DIV; i++)
            begin
                stg_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            mul_reg    <= mul_c;
            stg_reg[0] <= div0_c;
            for (int i = 1; i <= NUM_DIV; i++)
            begin
                stg_reg[i] <= div_step(stg_reg[i-1]);
            end
        end
    end

    // Output register is the last division stage
    assign empty         = !stg_reg[NUM_DIV].valid;
    assign kind          = stg_reg[NUM_DIV].kind;
    assign value         = stg_reg[NUM_DIV].sat ? '1 : stg_reg[NUM_DIV].value;
    assign cell_position = stg_reg[NUM_DIV].pos;

endmodule

// ===== rtl/flux_stream_byte_decoder.sv =====
// Top level of the flux stream byte decoder
//
//   channel   direction  handshake          payload
//   input     in         push / full        stream_byte, track_start
//   result    out        empty / pop        kind, value, cell_position
//   config    in         cfg_we             cfg_wdata (tick period, ps)
//
// One byte is taken per cycle while full is low; the parser decides each byte
// in the cycle it is taken. A result reaches the result ports through the
// queue, one multiply stage, one sum stage, and eight stages of the
// divide-by-1000 pipeline (4 quotient bits per stage). Reset clears the
// parser, the queue and all pipeline valids and loads the tick period with
// 41619. A held result stalls the pipeline; the two-entry queue then fills
// and raises full.
module flux_stream_byte_decoder #(
    parameter int ACCUM_BITS = fsb_pkg::FSB_ACCUM_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  stream_byte,
    input  logic        track_start,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [31:0] value,
    output logic [31:0] cell_position,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata
);
    import fsb_pkg::*;

    localparam int QW = $bits(fsb_evt_t) + ACCUM_BITS;

    logic [19:0]           tick_period_reg;
    logic                  accept;
    logic                  evt_valid;
    fsb_evt_t              evt;
    logic [ACCUM_BITS-1:0] evt_ticks;
    logic [QW-1:0]         q_rd_data;
    logic                  q_not_empty;
    logic                  q_take;
    fsb_evt_t              q_evt;
    logic [ACCUM_BITS-1:0] q_ticks;

    // Tick period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            tick_period_reg <= cfg_wdata;
        end
    end

    assign accept = push && !full;

    fsb_front #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .track_start (track_start),
        .evt_valid   (evt_valid),
        .evt         (evt),
        .evt_ticks   (evt_ticks)
    );

    fsb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (evt_valid),
        .wr_data   ({evt, evt_ticks}),
        .full      (full),
        .rd_en     (q_take),
        .rd_data   (q_rd_data),
        .not_empty (q_not_empty)
    );

    assign q_evt   = q_rd_data[QW-1:ACCUM_BITS];
    assign q_ticks = q_rd_data[ACCUM_BITS-1:0];

    fsb_back #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_period_ps (tick_period_reg),
        .in_valid       (q_not_empty),
        .in_evt         (q_evt),
        .in_ticks       (q_ticks),
        .in_take        (q_take),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .value          (value),
        .cell_position  (cell_position)
    );

endmodule

// ===== rtl/fsb_checker.sv =====
// Port-level checks for the flux stream byte decoder, bound to the top level
`include "flux_stream_byte_decoder_macros.svh"

module fsb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  stream_byte,
    input logic        track_start,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  kind,
    input logic [31:0] value,
    input logic [31:0] cell_position,
    input logic        cfg_we,
    input logic [19:0] cfg_wdata
);
    import fsb_pkg::*;

    // A waiting result stays put until taken
    `FSB_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(kind) && $stable(value) && $stable(cell_position), "result changed while waiting")

    // Only flux results carry a cell position
    `FSB_ASSERT_NOW(a_pos_flux_only, !empty && kind != KIND_FLUX, cell_position == 32'd0, "position on non-flux result")

    // Stop results carry one of the three causes
    `FSB_ASSERT_NOW(a_stop_cause, !empty && kind == KIND_STOP, value == CAUSE_INVALID || value == CAUSE_EOF || value == CAUSE_UNKNOWN, "bad stop cause")

endmodule

bind flux_stream_byte_decoder fsb_checker u_fsb_checker (.*);
